[src/pkira_pkg.sv]
// Package: shared types, codes and constants of the per-key id range allocator.
`timescale 1ns / 1ps
package pkira_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int ID_W        = 64;
    localparam int KEY_W       = 64;

    // Request codes; 4..7 are unknown requests
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_DROP   = 3'd1;
    localparam logic [2:0] REQ_ALLOC  = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARAM   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         start_value;
        logic                    has_start;
        logic [ID_W-1:0]         amount;
        logic                    has_amount;
        logic                    force_req;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] end_id;
    } t_rsp;

    // Write command broadcast to the entry cells
    typedef struct packed {
        logic             we;
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_wr;

endpackage

[src/pkira_cell.sv]
// Module: one table entry with its valid bit, key, next id and key comparator.
`timescale 1ns / 1ps
module pkira_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pkira_pkg::KEY_W-1:0] i_key,
    input  logic                      i_sel,
    input  pkira_pkg::t_wr            i_wr,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [pkira_pkg::ID_W-1:0] o_id_masked
);
    import pkira_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [ID_W-1:0]   r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.we && i_sel) begin
            r_valid <= i_wr.valid;
        end
    end

    // payload needs no reset: only read while valid
    always_ff @(posedge i_clk) begin
        if (i_wr.we && i_sel) begin
            r_key <= i_wr.key;
            r_id  <= i_wr.id;
        end
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_valid && (r_key == i_key);
    assign o_id_masked = o_hit ? r_id : '0;

endmodule

[src/pkira_exec.sv]
// Module: request decode, id arithmetic and table write command generation.
`timescale 1ns / 1ps
module pkira_exec #(
    parameter int ENTRIES = pkira_pkg::ENTRIES_DEF
) (
    input  pkira_pkg::t_req              i_req,
    input  logic [ENTRIES-1:0]           i_hit,
    input  logic [ENTRIES-1:0]           i_valid,
    input  logic [pkira_pkg::ID_W-1:0]   i_stored,
    output logic [ENTRIES-1:0]           o_sel,
    output pkira_pkg::t_wr               o_wr,
    output pkira_pkg::t_rsp              o_rsp
);
    import pkira_pkg::*;

    logic               any_hit;
    logic               full;
    logic [ENTRIES-1:0] free_1h;
    logic [ID_W-1:0]    bound;
    logic [ID_W-1:0]    base;
    logic [ID_W-1:0]    alloc_end;
    logic [ID_W-1:0]    upd_id;

    assign any_hit   = |i_hit;
    assign full      = &i_valid;
    // lowest free slot as one-hot
    assign free_1h   = ~i_valid & (i_valid + ENTRIES'(1));
    assign bound     = i_req.start_value + ID_W'(1);
    assign base      = (i_req.has_start && (i_stored < bound)) ? bound : i_stored;
    assign alloc_end = base + i_req.amount;
    assign upd_id    = i_req.has_start ? bound : (i_stored + i_req.amount);

    always_comb begin
        o_rsp    = '{status: ST_OK, first_id: '0, end_id: '0};
        o_wr.we    = 1'b0;
        o_wr.valid = 1'b1;
        o_wr.key   = i_req.key;
        o_wr.id    = i_stored;
        o_sel      = i_hit;
        unique case (i_req.req_type)
            REQ_ADD: begin
                o_sel = free_1h;
                if (any_hit) begin
                    o_rsp.status = ST_PARAM;
                end else if (full) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    o_wr.we         = 1'b1;
                    o_wr.id         = i_req.start_value;
                    o_rsp.first_id  = i_req.start_value;
                end
            end
            REQ_DROP: begin
                if (!any_hit) begin
                    o_rsp.status = ST_PARAM;
                end else begin
                    o_wr.we    = 1'b1;
                    o_wr.valid = 1'b0;
                end
            end
            REQ_ALLOC: begin
                if (!any_hit) begin
                    o_rsp.status = ST_PARAM;
                end else begin
                    o_wr.we        = 1'b1;
                    o_wr.id        = alloc_end;
                    o_rsp.first_id = base;
                    o_rsp.end_id   = alloc_end;
                end
            end
            REQ_UPDATE: begin
                if (!any_hit || (i_req.has_start == i_req.has_amount)) begin
                    o_rsp.status = ST_PARAM;
                end else if (i_req.has_start && (i_stored > bound) && !i_req.force_req) begin
                    o_rsp.status = ST_PARAM;
                end else begin
                    o_wr.we        = 1'b1;
                    o_wr.id        = upd_id;
                    o_rsp.first_id = upd_id;
                end
            end
            default: begin
                o_rsp.status = ST_UNKNOWN;
            end
        endcase
    end

endmodule

[src/per_key_id_range_allocator_top.sv]
// Top level: per-key id range allocator with a fully associative entry table.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive i_req and raise i_start; the transaction is taken at
//   any rising edge where i_start is high and o_busy is low. o_busy stays low,
//   so a request may be issued on every cycle.
//   Result channel: o_valid pulses for exactly one cycle with o_rsp; the
//   receiver must take it then, it has no way to stall the block.
//   The accepted request passes through the input register, then one pass of
//   compare, arithmetic and table write into the result register.
//   Throughput: 1 request per cycle.
//   The rate is set by the execute pass: a parallel key compare over all
//   ENTRIES cells, an OR-select of the matching id and 64-bit adds/compares.
//   The table is written at the same edge that registers the result, so the
//   next request already sees the update.
//   Reset (synchronous, active low) clears all valid bits at once and drops
//   any request in flight; keys and ids are left as they are and are never read
//   before being written.
module per_key_id_range_allocator_top #(
    parameter int ENTRIES = pkira_pkg::ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pkira_pkg::t_req i_req,
    output logic            o_busy,
    output logic            o_valid,
    output pkira_pkg::t_rsp o_rsp
);
    import pkira_pkg::*;

    logic               r_req_vld;
    t_req               r_req;
    logic               r_rsp_vld;
    t_rsp               r_rsp;

    logic [ENTRIES-1:0] hit;
    logic [ENTRIES-1:0] valid;
    logic [ID_W-1:0]    id_masked [ENTRIES];
    logic [ID_W-1:0]    stored;
    logic [ENTRIES-1:0] sel;
    t_wr                wr;
    t_wr                wr_gated;
    t_rsp               n_rsp;

    // Never back-pressure: every request finishes in one pass
    assign o_busy = 1'b0;

    // Input register: hold the accepted transaction for the execute pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_req <= i_req;
        end
    end

    // Entry table: one cell per slot, all compared in parallel
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pkira_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_req.key),
            .i_sel       (sel[g]),
            .i_wr        (wr_gated),
            .o_valid     (valid[g]),
            .o_hit       (hit[g]),
            .o_id_masked (id_masked[g])
        );
    end

    // Keys are unique, so at most one cell drives a nonzero id
    always_comb begin
        stored = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            stored = stored | id_masked[i];
        end
    end

    pkira_exec #(
        .ENTRIES (ENTRIES)
    ) u_exec (
        .i_req    (r_req),
        .i_hit    (hit),
        .i_valid  (valid),
        .i_stored (stored),
        .o_sel    (sel),
        .o_wr     (wr),
        .o_rsp    (n_rsp)
    );

    // Drop table writes when no request is in the execute stage
    always_comb begin
        wr_gated    = wr;
        wr_gated.we = wr.we && r_req_vld;
    end

    // Result register: advance one strobe per executed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_valid)
        else $error("executed request produced no result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_req_vld |=> !o_valid)
        else $error("result strobe without an executed request");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(hit) <= 1)
        else $error("key present in more than one table entry");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && n_rsp.status == ST_FULL) |-> (&valid))
        else $error("table full reported with a free entry");
`endif

endmodule
